/* sv/mrfe_pkg.sv */
// Shared types, constants and helpers for the region fit and encode block.
package mrfe_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned WIDE_W = ADDR_W + 1;
    localparam int unsigned LG_W   = 6;

    localparam logic [ADDR_W-1:0] WIN_ALIGN_MASK = 32'hFFFF_FFE0;
    localparam logic [WIDE_W-1:0] WIN_MIN_SIZE   = 33'd32;
    localparam logic [ADDR_W-1:0] BASE_VALID     = 32'h0000_0010;
    localparam logic [4:0]        ALIGN_NONE     = 5'd31;
    localparam logic [4:0]        ROUND_LAST     = 5'd31;
    localparam logic [2:0]        AP_FULL        = 3'd3;
    localparam logic [2:0]        AP_PRIV_RW     = 3'd2;

    typedef struct packed {
        logic        block_present;
        logic [31:0] block_start;
        logic [31:0] block_last;
        logic [31:0] cover_addr;
        logic        write_allowed;
        logic        exec_allowed;
        logic [3:0]  slot_number;
    } mrfe_in_t;

    typedef struct packed {
        logic [31:0] base_word;
        logic [31:0] attr_word;
    } mrfe_out_t;

    // top level -> window unit
    typedef struct packed {
        logic go;
        logic present;
        logic search;
        logic out_free;
    } mrfe_ctl_t;

    // window unit -> top level
    typedef struct packed {
        logic idle;
        logic done;
    } mrfe_rsp_t;

    // Lowest set bit at or above bit 5; ALIGN_NONE when those bits are all zero.
    function automatic logic [4:0] align_of(input logic [ADDR_W-1:0] v);
        logic [4:0] r;
        r = ALIGN_NONE;
        for (int i = ADDR_W - 1; i >= 5; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

/* sv/mpu_region_fit_and_encode_top.sv */
// Top level: request capture, mode register, word encoding and result register.
// Flow, per accepted request: an absent block goes straight to the result;
//   search mode runs R search rounds (at most 32) and then S shrink steps;
//   whole-block mode measures, then takes L log steps, L = floor(log2(block size)), at most 32.
// Throughput: one request at a time; the next is taken the cycle after the
//   result enters the output register.
// Reset: synchronous, active low; clears control state, cover_mode to 1.
module mpu_region_fit_and_encode_top
    import mrfe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  mrfe_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mrfe_out_t m_data
);

    logic            cover_mode_reg;
    logic            present_reg;
    logic            wr_reg;
    logic            ex_reg;
    logic [3:0]      slot_reg;
    logic            m_valid_reg, m_valid_next;
    mrfe_out_t       m_data_reg, m_data_next;

    mrfe_ctl_t       ctl;
    mrfe_rsp_t       rsp;
    logic [ADDR_W-1:0] win_lo;
    logic [LG_W-1:0]   win_lg;
    logic [LG_W-1:0]   lg_m1;
    logic [4:0]        size_code;
    logic [2:0]        ap;
    logic              take;
    logic              out_free;
    logic              load;

    // Take a request only while the window unit sits idle.
    assign s_ready  = rsp.idle;
    assign take     = s_valid && s_ready;
    // The output slot frees up once the held result is taken.
    assign out_free = !m_valid_reg || m_ready;
    assign load     = rsp.done && out_free;

    assign ctl.go       = take;
    assign ctl.present  = s_data.block_present;
    assign ctl.search   = cover_mode_reg;
    assign ctl.out_free = out_free;

    mrfe_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .block_start (s_data.block_start),
        .block_last  (s_data.block_last),
        .cover_addr  (s_data.cover_addr),
        .rsp         (rsp),
        .win_lo      (win_lo),
        .win_lg      (win_lg)
    );

    // Size code is floor(log2(size)) - 1, saturated at zero.
    assign lg_m1     = win_lg - LG_W'(1);
    assign size_code = (win_lg == '0) ? 5'd0 : lg_m1[4:0];
    assign ap        = wr_reg ? AP_FULL : AP_PRIV_RW;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            if (present_reg) begin
                m_data_next.base_word = win_lo | BASE_VALID | {28'd0, slot_reg};
                m_data_next.attr_word = {3'd0, !ex_reg, 1'b0, ap, 18'd0, size_code, 1'b1};
            end else begin
                // absent block: disabled entry, slot still selected
                m_data_next.base_word = BASE_VALID | {28'd0, slot_reg};
                m_data_next.attr_word = '0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cover_mode_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                cover_mode_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        // Hold the encode-only fields of the request until the result loads.
        if (take) begin
            present_reg <= s_data.block_present;
            wr_reg      <= s_data.write_allowed;
            ex_reg      <= s_data.exec_allowed;
            slot_reg    <= s_data.slot_number;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/mrfe_window.sv */
// Iterative window search and size measurement unit around one shared adder.
module mrfe_window
    import mrfe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mrfe_ctl_t         ctl,
    input  logic [ADDR_W-1:0] block_start,
    input  logic [ADDR_W-1:0] block_last,
    input  logic [ADDR_W-1:0] cover_addr,
    output mrfe_rsp_t         rsp,
    output logic [ADDR_W-1:0] win_lo,
    output logic [LG_W-1:0]   win_lg
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROUND  = 3'd1;
    localparam logic [2:0] ST_SHRINK = 3'd2;
    localparam logic [2:0] ST_SIZE   = 3'd3;
    localparam logic [2:0] ST_LOG    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [WIDE_W-1:0] bot_reg, bot_next;
    logic [WIDE_W-1:0] top_reg, top_next;
    logic [WIDE_W-1:0] start_reg, start_next;
    logic [WIDE_W-1:0] end_reg, end_next;
    logic [WIDE_W-1:0] v_reg, v_next;
    logic [LG_W-1:0]   k_reg, k_next;
    logic [LG_W-1:0]   lg_reg, lg_next;
    logic [4:0]        rnd_reg, rnd_next;
    logic              dir_reg, dir_next;

    logic [4:0]        ta, ba;
    logic              mv_bot;
    logic [LG_W-1:0]   kk;
    logic [WIDE_W-1:0] opa, opb;
    logic              sub;
    logic [WIDE_W:0]   sum;
    logic              fail;
    logic [WIDE_W-1:0] cov_bot;

    assign ta      = align_of(top_reg[ADDR_W-1:0]);
    assign ba      = align_of(bot_reg[ADDR_W-1:0]);
    assign cov_bot = {1'b0, cover_addr & WIN_ALIGN_MASK};

    // Shared adder: step an end by a power of two, or measure the window.
    always_comb begin
        mv_bot = 1'b0;
        kk     = '0;
        opa    = bot_reg;
        opb    = '0;
        sub    = 1'b0;
        case (state_reg)
            ST_ROUND: begin
                mv_bot = (ta > ba);
                kk     = mv_bot ? LG_W'(ta) : LG_W'(ba);
            end
            ST_SHRINK: begin
                mv_bot = dir_reg;
                kk     = k_reg - LG_W'(1);
            end
            default: begin
                mv_bot = 1'b0;
                kk     = '0;
            end
        endcase
        if (state_reg == ST_SIZE) begin
            opa = top_reg;
            opb = bot_reg;
            sub = 1'b1;
        end else if (mv_bot) begin
            opa = top_reg;
            opb = WIDE_W'(1) << kk;
            sub = 1'b1;
        end else begin
            opa = bot_reg;
            opb = WIDE_W'(1) << kk;
            sub = 1'b0;
        end
        sum  = sub ? ({1'b0, opa} - {1'b0, opb}) : ({1'b0, opa} + {1'b0, opb});
        fail = mv_bot ? (sum[WIDE_W-1:0] < start_reg) : (sum[WIDE_W-1:0] > end_reg);
    end

    always_comb begin
        state_next = state_reg;
        bot_next   = bot_reg;
        top_next   = top_reg;
        start_next = start_reg;
        end_next   = end_reg;
        v_next     = v_reg;
        k_next     = k_reg;
        lg_next    = lg_reg;
        rnd_next   = rnd_reg;
        dir_next   = dir_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctl.go) begin
                    start_next = {1'b0, block_start};
                    end_next   = {1'b0, block_last} + WIDE_W'(1);
                    rnd_next   = '0;
                    lg_next    = '0;
                    if (!ctl.present) begin
                        state_next = ST_DONE;
                    end else if (ctl.search) begin
                        bot_next   = cov_bot;
                        top_next   = cov_bot + WIN_MIN_SIZE;
                        state_next = ST_ROUND;
                    end else begin
                        bot_next   = {1'b0, block_start};
                        top_next   = {1'b0, block_last} + WIDE_W'(1);
                        state_next = ST_SIZE;
                    end
                end
            end
            ST_ROUND: begin
                if (mv_bot) begin
                    bot_next = sum[WIDE_W-1:0];
                end else begin
                    top_next = sum[WIDE_W-1:0];
                end
                if (fail) begin
                    k_next     = kk;
                    dir_next   = mv_bot;
                    state_next = ST_SHRINK;
                end else begin
                    lg_next  = kk;
                    rnd_next = rnd_reg + 5'd1;
                    if (rnd_reg == ROUND_LAST) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SHRINK: begin
                if (dir_reg) begin
                    bot_next = sum[WIDE_W-1:0];
                end else begin
                    top_next = sum[WIDE_W-1:0];
                end
                k_next = kk;
                if (!fail || kk == '0) begin
                    lg_next    = kk;
                    state_next = ST_DONE;
                end
            end
            ST_SIZE: begin
                // empty or inverted window measures as zero
                if (!sum[WIDE_W] && sum[WIDE_W-1:0] != '0) begin
                    v_next = sum[WIDE_W-1:0];
                end else begin
                    v_next = '0;
                end
                lg_next    = '0;
                state_next = ST_LOG;
            end
            ST_LOG: begin
                if (v_reg[WIDE_W-1:1] != '0) begin
                    v_next  = v_reg >> 1;
                    lg_next = lg_reg + LG_W'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ctl.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bot_reg   <= bot_next;
        top_reg   <= top_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        v_reg     <= v_next;
        k_reg     <= k_next;
        lg_reg    <= lg_next;
        rnd_reg   <= rnd_next;
        dir_reg   <= dir_next;
    end

    assign rsp.idle = (state_reg == ST_IDLE);
    assign rsp.done = (state_reg == ST_DONE);
    assign win_lo   = bot_reg[ADDR_W-1:0];
    assign win_lg   = lg_reg;

endmodule

/* sv/mrfe_checker.sv */
// Port-level checker for the region fit and encode block, with its bind.
module mrfe_checker
    import mrfe_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input mrfe_out_t m_data
);

    // One request at a time: the input closes right after a request is taken.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after a request was taken");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    a_reserved_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.base_word[4] && m_data.attr_word[31:29] == 3'd0 &&
                    !m_data.attr_word[27] && m_data.attr_word[23:6] == 18'd0)
        else $error("reserved result bits set");

    a_access_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.attr_word[0] &&
                     (m_data.attr_word[26:24] == AP_FULL ||
                      m_data.attr_word[26:24] == AP_PRIV_RW)) ||
                    m_data.attr_word == 32'd0)
        else $error("bad access code or partial disabled entry");

endmodule

bind mpu_region_fit_and_encode_top mrfe_checker u_mrfe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
